// ----- rtl/sps_pkg.sv -----
`timescale 1ns / 1ps
package sps_pkg;
   localparam int MAX_PROCS = 16;
   localparam int PASS_BITS = 32;
   localparam int IDX_W     = $clog2(MAX_PROCS);
   localparam int CNT_W     = $clog2(MAX_PROCS + 1);
   localparam int PID_W     = 16;
   localparam int TKT_W     = 16;
   localparam int STRIDE_W  = 20;
   localparam int KEY_W     = PASS_BITS + PID_W;
   localparam logic [STRIDE_W-1:0] NUM_RESET = STRIDE_W'(1000000);

   // event kinds
   localparam logic [2:0] K_ARRIVE    = 3'd0;
   localparam logic [2:0] K_SLICE     = 3'd1;
   localparam logic [2:0] K_BLOCK     = 3'd2;
   localparam logic [2:0] K_UNBLOCK   = 3'd3;
   localparam logic [2:0] K_TERMINATE = 3'd4;

   // status codes
   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_UNKNOWN = 2'd2;
   localparam logic [1:0] ST_ZERO    = 2'd3;

   typedef struct packed {
      logic [PID_W-1:0]     ident;
      logic [STRIDE_W-1:0]  stride;
      logic [PASS_BITS-1:0] pass;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);
endpackage

// ----- rtl/sps_ram.sv -----
`timescale 1ns / 1ps
module sps_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   // one write port, registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

// ----- rtl/sps_div.sv -----
`timescale 1ns / 1ps
module sps_div import sps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic [STRIDE_W-1:0] dividend,
   input  logic [TKT_W-1:0]    divisor,
   output logic                done,
   output logic [STRIDE_W-1:0] quotient
);
   localparam int STEP_W = $clog2(STRIDE_W + 1);

   logic [TKT_W-1:0]    rem_ff;
   logic [STRIDE_W-1:0] quo_ff;
   logic [TKT_W-1:0]    den_ff;
   logic [STEP_W-1:0]   cnt_ff;
   logic                busy_ff;
   logic                done_ff;
   logic [TKT_W:0]      shifted;
   logic [TKT_W+1:0]    diff;

   // one quotient bit per cycle, restoring
   assign shifted = {rem_ff, quo_ff[STRIDE_W-1]};
   assign diff    = {1'b0, shifted} - {2'b00, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= STEP_W'(STRIDE_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == STEP_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= '0;
         quo_ff <= dividend;
         den_ff <= divisor;
      end else if (busy_ff) begin
         if (!diff[TKT_W+1]) begin
            rem_ff <= diff[TKT_W-1:0];
            quo_ff <= {quo_ff[STRIDE_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[TKT_W-1:0];
            quo_ff <= {quo_ff[STRIDE_W-2:0], 1'b0};
         end
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

// ----- rtl/stride_process_scheduler.sv -----
`timescale 1ns / 1ps
// throughput: one transaction at a time, set by up to two sequential sweeps over the
//   entry memory (one read per cycle), plus the stride divider on an arrive; a
//   finished result may wait while the next is taken
// reset: synchronous, clears the used bits and loads the numerator with 1000000
module stride_process_scheduler import sps_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [2:0]          req_kind,
   input  logic [PID_W-1:0]    req_pid,
   input  logic [TKT_W-1:0]    req_tickets,
   input  logic                req_running_valid,
   input  logic [PID_W-1:0]    req_running_pid,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_switch_valid,
   output logic [PID_W-1:0]    rsp_switch_pid,
   output logic [1:0]          rsp_status,
   input  logic                csr_wr_en,
   input  logic [STRIDE_W-1:0] csr_wr_data
);
   typedef enum logic [2:0] {
      S_IDLE, S_FIND, S_DECIDE, S_DIV, S_SCAN, S_FINAL
   } state_type;

   state_type            state_ff;
   logic [STRIDE_W-1:0]  num_ff;
   logic [MAX_PROCS-1:0] used_ff;
   logic [MAX_PROCS-1:0] blk_ff;

   logic [2:0]           kind_ff;
   logic [PID_W-1:0]     pid_ff;
   logic [TKT_W-1:0]     tkt_ff;
   logic                 run_v_ff;
   logic [PID_W-1:0]     run_pid_ff;

   logic [CNT_W-1:0]     cnt_ff;
   logic                 rd_vld_ff;
   logic [IDX_W-1:0]     rd_idx_ff;
   logic                 found_ff;
   logic [IDX_W-1:0]     e_idx_ff;
   entry_type            e_data_ff;
   logic                 free_v_ff;
   logic [IDX_W-1:0]     free_idx_ff;
   logic [IDX_W-1:0]     slot_ff;
   logic                 idle_only_ff;
   logic                 blk_mode_ff;
   logic                 best_v_ff;
   logic [KEY_W-1:0]     best_key_ff;
   logic                 nxt_v_ff;
   logic [KEY_W-1:0]     nxt_key_ff;
   logic [1:0]           status_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_sw_ff;
   logic [PID_W-1:0]     rsp_pid_ff;
   logic [1:0]           rsp_status_ff;

   logic                 ram_we;
   logic [IDX_W-1:0]     ram_waddr;
   entry_type            ram_wdata;
   entry_type            ram_rdata;
   logic                 rd_issue;
   logic                 div_start;
   logic                 div_done;
   logic [STRIDE_W-1:0]  div_quo;
   logic [PASS_BITS:0]   pass_sum;
   logic [PASS_BITS-1:0] pass_sat;
   logic                 e_ok;
   logic                 rd_ready;
   logic [KEY_W-1:0]     rd_key;
   logic [KEY_W-1:0]     e_key;
   logic                 tgt_v;
   logic [PID_W-1:0]     tgt_pid;
   logic                 go;

   assign req_stall = (state_ff != S_IDLE);

   // entry memory: ident, stride, pass
   sps_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_PROCS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (cnt_ff[IDX_W-1:0]),
      .rd_data (ram_rdata)
   );

   sps_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (num_ff),
      .divisor  (tkt_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // saturating pass update of the matched entry
   assign pass_sum = {1'b0, e_data_ff.pass} + (PASS_BITS + 1)'(e_data_ff.stride);
   assign pass_sat = pass_sum[PASS_BITS] ? '1 : pass_sum[PASS_BITS-1:0];
   assign e_ok     = found_ff && !blk_ff[e_idx_ff];

   assign rd_issue  = (state_ff == S_FIND || state_ff == S_SCAN) &&
                      (cnt_ff < CNT_W'(MAX_PROCS));
   assign div_start = (state_ff == S_DECIDE) && (kind_ff == K_ARRIVE) &&
                      (tkt_ff != '0) && (found_ff || free_v_ff);

   // memory write: pass update on decide, new entry when the divider ends
   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = e_idx_ff;
      ram_wdata = '{ident: pid_ff, stride: e_data_ff.stride, pass: pass_sat};
      if (state_ff == S_DECIDE && e_ok && (kind_ff == K_SLICE || kind_ff == K_BLOCK)) begin
         ram_we = 1'b1;
      end else if (state_ff == S_DIV && div_done) begin
         ram_we    = 1'b1;
         ram_waddr = slot_ff;
         ram_wdata = '{ident: pid_ff, stride: div_quo, pass: '0};
      end
   end

   // ordering keys: pass first, then pid
   assign rd_ready = used_ff[rd_idx_ff] && !blk_ff[rd_idx_ff];
   assign rd_key   = {ram_rdata.pass, ram_rdata.ident};
   assign e_key    = {e_data_ff.pass, pid_ff};

   // switch decision
   always_comb begin
      tgt_v   = best_v_ff;
      tgt_pid = best_key_ff[PID_W-1:0];
      if (blk_mode_ff && nxt_v_ff) begin
         tgt_v   = 1'b1;
         tgt_pid = nxt_key_ff[PID_W-1:0];
      end
      if (idle_only_ff) begin
         go = tgt_v && !run_v_ff;
      end else begin
         go = tgt_v && (!run_v_ff || tgt_pid != run_pid_ff);
      end
   end

   // numerator register
   always_ff @(posedge clock) begin
      if (reset) begin
         num_ff <= NUM_RESET;
      end else if (csr_wr_en) begin
         num_ff <= csr_wr_data;
      end
   end

   // used bits
   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else if (state_ff == S_DIV && div_done) begin
         used_ff[slot_ff] <= 1'b1;
      end else if (state_ff == S_DECIDE && e_ok && kind_ff == K_TERMINATE) begin
         used_ff[e_idx_ff] <= 1'b0;
      end
   end

   // blocked marks, meaningful only for used entries
   always_ff @(posedge clock) begin
      if (state_ff == S_DIV && div_done) begin
         blk_ff[slot_ff] <= 1'b0;
      end else if (state_ff == S_DECIDE && found_ff) begin
         if (kind_ff == K_UNBLOCK && blk_ff[e_idx_ff]) begin
            blk_ff[e_idx_ff] <= 1'b0;
         end else if (kind_ff == K_BLOCK && !blk_ff[e_idx_ff]) begin
            blk_ff[e_idx_ff] <= 1'b1;
         end
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         rd_vld_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         rd_vld_ff <= rd_issue;
         rd_idx_ff <= cnt_ff[IDX_W-1:0];
         if (rd_issue) begin
            cnt_ff <= cnt_ff + 1'b1;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  kind_ff      <= req_kind;
                  pid_ff       <= req_pid;
                  tkt_ff       <= req_tickets;
                  run_v_ff     <= req_running_valid;
                  run_pid_ff   <= req_running_pid;
                  cnt_ff       <= '0;
                  found_ff     <= 1'b0;
                  free_v_ff    <= 1'b0;
                  best_v_ff    <= 1'b0;
                  nxt_v_ff     <= 1'b0;
                  idle_only_ff <= 1'b0;
                  blk_mode_ff  <= 1'b0;
                  status_ff    <= ST_OK;
                  state_ff     <= S_FIND;
               end
            end
            S_FIND: begin
               // look up the pid and the first free slot
               if (rd_vld_ff) begin
                  if (used_ff[rd_idx_ff] && ram_rdata.ident == pid_ff && !found_ff) begin
                     found_ff  <= 1'b1;
                     e_idx_ff  <= rd_idx_ff;
                     e_data_ff <= ram_rdata;
                  end
                  if (!used_ff[rd_idx_ff] && !free_v_ff) begin
                     free_v_ff   <= 1'b1;
                     free_idx_ff <= rd_idx_ff;
                  end
               end
               if (!rd_issue && !rd_vld_ff) begin
                  state_ff <= S_DECIDE;
               end
            end
            S_DECIDE: begin
               cnt_ff <= '0;
               case (kind_ff)
                  K_ARRIVE: begin
                     if (tkt_ff == '0) begin
                        status_ff <= ST_ZERO;
                        state_ff  <= S_FINAL;
                     end else if (!found_ff && !free_v_ff) begin
                        status_ff <= ST_FULL;
                        state_ff  <= S_FINAL;
                     end else begin
                        slot_ff      <= found_ff ? e_idx_ff : free_idx_ff;
                        idle_only_ff <= 1'b1;
                        state_ff     <= S_DIV;
                     end
                  end
                  K_UNBLOCK: begin
                     if (!found_ff || !blk_ff[e_idx_ff]) begin
                        status_ff <= ST_UNKNOWN;
                        state_ff  <= S_FINAL;
                     end else begin
                        idle_only_ff <= 1'b1;
                        state_ff     <= S_SCAN;
                     end
                  end
                  K_SLICE, K_BLOCK, K_TERMINATE: begin
                     if (!e_ok) begin
                        status_ff <= ST_UNKNOWN;
                        state_ff  <= S_FINAL;
                     end else begin
                        blk_mode_ff <= (kind_ff == K_BLOCK);
                        state_ff    <= S_SCAN;
                     end
                  end
                  default: begin
                     state_ff <= S_FINAL;
                  end
               endcase
            end
            S_DIV: begin
               if (div_done) begin
                  state_ff <= S_SCAN;
               end
            end
            S_SCAN: begin
               // minimum over ready entries, and the successor of a blocked entry
               if (rd_vld_ff && rd_ready) begin
                  if (!best_v_ff || rd_key < best_key_ff) begin
                     best_v_ff   <= 1'b1;
                     best_key_ff <= rd_key;
                  end
                  if (blk_mode_ff && e_key < rd_key && (!nxt_v_ff || rd_key < nxt_key_ff)) begin
                     nxt_v_ff   <= 1'b1;
                     nxt_key_ff <= rd_key;
                  end
               end
               if (!rd_issue && !rd_vld_ff) begin
                  state_ff <= S_FINAL;
               end
            end
            S_FINAL: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_sw_ff     <= go;
                  rsp_pid_ff    <= go ? tgt_pid : '0;
                  rsp_status_ff <= status_ff;
                  state_ff      <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_switch_valid = rsp_sw_ff;
   assign rsp_switch_pid   = rsp_pid_ff;
   assign rsp_status       = rsp_status_ff;

   // an error status never orders a switch
   a_err_no_switch: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |-> !rsp_switch_valid)
      else $error("switch ordered with error status");

   // no switch means a zero pid
   a_pid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_switch_valid |-> rsp_switch_pid == '0)
      else $error("nonzero pid without switch");

   // an accepted transaction keeps the input stalled in the next cycle
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input not stalled after accept");

   // the divider only finishes while the sequencer waits for it
   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == S_DIV)
      else $error("divider done outside divide phase");
endmodule
